/* rtl/sacl_pkg.sv */
// sacl_pkg: shared types and constants for the set-associative lru cache tag block
// used by the channel interfaces and the top level; no dependencies

package sacl_pkg;

  // address and field widths
  localparam int AddrW   = 64;
  localparam int StampW  = 64;
  localparam int SetOutW = 8;
  localparam int WayOutW = 3;
  localparam int SetCap  = 8;

  // configuration register codes (word index on the apb port)
  localparam logic [1:0] RegOffsetBits = 2'd0;
  localparam logic [1:0] RegSetBits    = 2'd1;
  localparam logic [1:0] RegWayBits    = 2'd2;

  // configuration reset values
  localparam logic [5:0] OffsetBitsRst = 6'd5;
  localparam logic [3:0] SetBitsRst    = 4'd6;
  localparam logic [1:0] WayBitsRst    = 2'd2;

  // one way of a set as kept in the tag store
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AddrW-1:0]  tag;
    logic [StampW-1:0] stamp;
  } way_t;

endpackage

/* rtl/sacl_ifs.sv */
// sacl_ifs: valid/ready channel interfaces for access requests and results
// depends on sacl_pkg for field widths

interface sacl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [sacl_pkg::AddrW-1:0]  address;

  modport source (output valid, output func, output address, input ready);
  modport sink   (input valid, input func, input address, output ready);
endinterface

interface sacl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          write_back;
  logic                          replaced_valid;
  logic [sacl_pkg::WayOutW-1:0]  way_used;
  logic [sacl_pkg::SetOutW-1:0]  set_used;

  modport source (output valid, output hit, output write_back, output replaced_valid,
                  output way_used, output set_used, input ready);
  modport sink   (input valid, input hit, input write_back, input replaced_valid,
                  input way_used, input set_used, output ready);
endinterface

/* rtl/set_assoc_lru_cache_tags.sv */
// set_assoc_lru_cache_tags: tag store and lru replacement of a write-back cache
// depends on sacl_pkg and the sacl_req_if / sacl_rsp_if interfaces
//
//  channel   dir  transfer when            payload
//  req_i     in   valid & ready            func, address
//  rsp_o     out  valid & ready            hit, write_back, replaced_valid, way_used, set_used
//  apb       in   psel&penable&pwrite      offset_bits, set_bits, way_bits (words 0, 1, 2)
//
// one access per cycle while rsp_o is not stalled; the set row is read into the lookup stage at the
// request transfer, then tag match, lru pick and row write happen there and the result is registered.
// back-to-back accesses to the same set take the freshly written row from a bypass register.
// reset clears the store through one row-valid flop per set; no clearing pass is needed.
// a stalled result holds the lookup stage, and req_i.ready drops only while both are full.

module set_assoc_lru_cache_tags #(
  parameter int MAX_SETS = 256,
  parameter int MAX_WAYS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sacl_req_if.sink          req_i,
  sacl_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // only 256 sets and 8 ways are reachable through the registers
  localparam int Rows  = (MAX_SETS < 256) ? MAX_SETS : 256;
  localparam int SetW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int NWays = (MAX_WAYS < 8) ? MAX_WAYS : 8;
  localparam int WayW  = (NWays > 1) ? $clog2(NWays) : 1;

  typedef sacl_pkg::way_t [NWays-1:0] row_t;

  // configuration registers
  logic [5:0] ob_q;
  logic [3:0] sb_q;
  logic [1:0] wb_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_q <= sacl_pkg::OffsetBitsRst;
      sb_q <= sacl_pkg::SetBitsRst;
      wb_q <= sacl_pkg::WayBitsRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        sacl_pkg::RegOffsetBits: ob_q <= pwdata[5:0];
        sacl_pkg::RegSetBits:    sb_q <= pwdata[3:0];
        sacl_pkg::RegWayBits:    wb_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      sacl_pkg::RegOffsetBits: prdata = {26'd0, ob_q};
      sacl_pkg::RegSetBits:    prdata = {28'd0, sb_q};
      sacl_pkg::RegWayBits:    prdata = {30'd0, wb_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // raw set index folded into the stored rows
  logic [SetW-1:0] set_map [256];
  for (genvar gi = 0; gi < 256; gi++) begin : g_set_map
    assign set_map[gi] = SetW'(gi % MAX_SETS);
  end

  // handshake control
  logic s1_v_q, out_v_q;
  logic in_fire, s1_fire;

  assign s1_fire     = s1_v_q & (~out_v_q | rsp_o.ready);
  assign req_i.ready = ~s1_v_q | s1_fire;
  assign in_fire     = req_i.valid & req_i.ready;

  // set and tag of the incoming access
  logic [3:0]                 sb_eff;
  logic [sacl_pkg::AddrW-1:0] addr_sh;
  logic [8:0]                 set_mask;
  logic [7:0]                 set_raw;
  logic [SetW-1:0]            set_in;
  logic [6:0]                 tshift;
  logic [sacl_pkg::AddrW-1:0] tag_in;

  always_comb begin
    sb_eff   = (sb_q > 4'(sacl_pkg::SetCap)) ? 4'(sacl_pkg::SetCap) : sb_q;
    addr_sh  = req_i.address >> ob_q;
    set_mask = (9'd1 << sb_eff) - 9'd1;
    set_raw  = addr_sh[7:0] & set_mask[7:0];
    set_in   = set_map[set_raw];
    tshift   = {1'b0, ob_q} + {3'b000, sb_eff};
    tag_in   = tshift[6] ? '0 : (req_i.address >> tshift[5:0]);
  end

  // lookup stage registers
  logic                       s1_wr_q;
  logic [SetW-1:0]            s1_set_q;
  logic [sacl_pkg::AddrW-1:0] s1_tag_q;
  row_t                       rd_row_q;
  row_t                       byp_row_q;
  logic                       rd_ok_q;
  logic                       byp_q;
  logic [Rows-1:0]            row_ok_q;
  logic [sacl_pkg::StampW-1:0] ctr_q;
  row_t                       mem_q [Rows];
  row_t                       row_cur;
  row_t                       row_new;
  logic                       same_set;

  assign same_set = s1_fire & (set_in == s1_set_q);

  // control state: valids, row-valid flags, stamp counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      rd_ok_q  <= 1'b0;
      byp_q    <= 1'b0;
      row_ok_q <= '0;
      ctr_q    <= '0;
    end else begin
      if (in_fire) begin
        s1_v_q  <= 1'b1;
        rd_ok_q <= row_ok_q[set_in];
        byp_q   <= same_set;
      end else if (s1_fire) begin
        s1_v_q <= 1'b0;
      end
      if (s1_fire) begin
        out_v_q            <= 1'b1;
        row_ok_q[s1_set_q] <= 1'b1;
        ctr_q              <= ctr_q + sacl_pkg::StampW'(1);
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // tag store: one row per set, written by the lookup stage
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      mem_q[s1_set_q] <= row_new;
    end
    if (in_fire) begin
      rd_row_q  <= mem_q[set_in];
      byp_row_q <= row_new;
      s1_wr_q   <= req_i.func;
      s1_set_q  <= set_in;
      s1_tag_q  <= tag_in;
    end
  end

  // tag match, free way search and lru pick
  logic [3:0]       ways_n;
  logic [NWays-1:0] on, hitv, inv, lru;
  logic             hit, any_inv;
  logic [WayW-1:0]  hit_way, inv_way, lru_way, pick;

  always_comb begin
    row_cur = byp_q ? byp_row_q : (rd_ok_q ? rd_row_q : '0);
    ways_n  = 4'd1 << wb_q;
    for (int w = 0; w < NWays; w++) begin
      on[w]   = 4'(w) < ways_n;
      hitv[w] = on[w] & row_cur[w].valid & (row_cur[w].tag == s1_tag_q);
      inv[w]  = on[w] & ~row_cur[w].valid;
      lru[w]  = on[w];
      for (int v = 0; v < NWays; v++) begin
        if (v < w) begin
          lru[w] = lru[w] & (~on[v] | (row_cur[w].stamp < row_cur[v].stamp));
        end else if (v > w) begin
          lru[w] = lru[w] & (~on[v] | (row_cur[w].stamp <= row_cur[v].stamp));
        end
      end
    end
    hit     = |hitv;
    any_inv = |inv;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    // lowest way wins
    for (int w = NWays - 1; w >= 0; w--) begin
      if (hitv[w]) hit_way = WayW'(w);
      if (inv[w])  inv_way = WayW'(w);
      if (lru[w])  lru_way = WayW'(w);
    end
    pick    = hit ? hit_way : (any_inv ? inv_way : lru_way);
    // updated row
    row_new = row_cur;
    row_new[pick].stamp = ctr_q;
    if (hit) begin
      row_new[pick].dirty = row_cur[pick].dirty | s1_wr_q;
    end else begin
      row_new[pick].valid = 1'b1;
      row_new[pick].dirty = s1_wr_q;
      row_new[pick].tag   = s1_tag_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rsp_o.hit            <= hit;
      rsp_o.write_back     <= ~hit & ~any_inv & row_cur[pick].dirty;
      rsp_o.replaced_valid <= ~hit & ~any_inv;
      rsp_o.way_used       <= sacl_pkg::WayOutW'(pick);
      rsp_o.set_used       <= sacl_pkg::SetOutW'(s1_set_q);
    end
  end

  assign rsp_o.valid = out_v_q;

endmodule
